/* sv/tccs_pkg.sv */
// shared types and constants for the text console cursor and scroll block
`timescale 1ns / 1ps
package tccs_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 32;

	// result queue depth and the most results one byte can cause
	localparam int QDEPTH = 8;
	localparam int SLOTS  = 4;

	localparam logic [7:0] CTRL_LOW_MAX = 8'h1F;
	localparam logic [7:0] CTRL_DEL     = 8'h7F;
	localparam logic [7:0] CTRL_C1_MAX  = 8'h9F;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] GLYPH_BASE   = 8'd32;

	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_INVERT = 2'd2
	} act_t;

	typedef struct packed {
		act_t       action;
		logic [5:0] phys_row;
		logic [6:0] column;
		logic [7:0] glyph;
		logic [5:0] top_row;
		logic       last_result;
	} res_t;

	// results of one byte in model order: invert, draw, clear, invert
	typedef struct packed {
		logic [SLOTS-1:0]            mask;
		res_t [SLOTS-1:0]            slot;
	} push_t;

endpackage

/* sv/tccs_core.sv */
// input register, cursor and scroll state, per-byte result generation
`timescale 1ns / 1ps
module tccs_core import tccs_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       first_in_request,
	input  logic       last_in_request,
	input  logic       room,
	output push_t      push
);

	localparam int COL_W = $clog2(COLUMNS);
	localparam int ROW_W = $clog2(ROWS);
	localparam int TOP_W = $clog2(ROWS + 1);
	localparam logic [TOP_W:0] NPHYS = (TOP_W + 1)'(ROWS + 1);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             first_s1;
	logic             last_s1;

	logic [COL_W-1:0] cursor_col_q;
	logic [ROW_W-1:0] cursor_row_q;
	logic [TOP_W-1:0] top_q;

	logic             go;
	logic             is_ctrl, is_lf, printable;
	logic             nl, bottom, scroll;
	logic [COL_W-1:0] col_next;
	logic [ROW_W-1:0] row_next;
	logic [TOP_W-1:0] top_inc, top_next;
	logic [TOP_W-1:0] phys_now, phys_after;
	logic [SLOTS-1:0] m;

	function automatic logic [TOP_W-1:0] phys_of(input logic [TOP_W-1:0] t,
			input logic [ROW_W-1:0] r);
		logic [TOP_W:0] s;
		s = {1'b0, t} + {{(TOP_W + 1 - ROW_W){1'b0}}, r};
		if (s >= NPHYS)
			s = s - NPHYS;
		return s[TOP_W-1:0];
	endfunction

	function automatic logic [5:0] to6(input logic [TOP_W-1:0] v);
		logic [TOP_W+5:0] w;
		w = {6'd0, v};
		return w[5:0];
	endfunction

	function automatic logic [6:0] to7(input logic [COL_W-1:0] v);
		logic [COL_W+6:0] w;
		w = {7'd0, v};
		return w[6:0];
	endfunction

	assign go       = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1  <= char_code;
			first_s1 <= first_in_request;
			last_s1  <= last_in_request;
		end
	end

	always_comb begin
		is_ctrl   = (char_s1 <= CTRL_LOW_MAX) ||
		            (char_s1 >= CTRL_DEL && char_s1 <= CTRL_C1_MAX);
		is_lf     = char_s1 == CHAR_LF;
		printable = ~is_ctrl;
		nl        = is_lf | (printable & (cursor_col_q == COL_W'(COLUMNS - 1)));
		bottom    = cursor_row_q == ROW_W'(ROWS - 1);
		scroll    = nl & bottom;

		if (nl)
			col_next = '0;
		else if (printable)
			col_next = cursor_col_q + COL_W'(1);
		else
			col_next = cursor_col_q;

		row_next = (nl && !bottom) ? cursor_row_q + ROW_W'(1) : cursor_row_q;
		top_inc  = (top_q == TOP_W'(ROWS)) ? '0 : top_q + TOP_W'(1);
		top_next = scroll ? top_inc : top_q;

		phys_now   = phys_of(top_q, cursor_row_q);
		phys_after = phys_of(top_next, row_next);

		m = {last_s1, scroll, printable, first_s1};
	end

	always_comb begin
		push.mask = go ? m : '0;

		push.slot[0].action      = ACT_INVERT;
		push.slot[0].phys_row    = to6(phys_now);
		push.slot[0].column      = to7(cursor_col_q);
		push.slot[0].glyph       = '0;
		push.slot[0].top_row     = to6(top_q);
		push.slot[0].last_result = ~|m[3:1];

		push.slot[1].action      = ACT_DRAW;
		push.slot[1].phys_row    = to6(phys_now);
		push.slot[1].column      = to7(cursor_col_q);
		push.slot[1].glyph       = char_s1 - GLYPH_BASE;
		push.slot[1].top_row     = to6(top_q);
		push.slot[1].last_result = ~|m[3:2];

		// clear names the old top row but reports the rotated top
		push.slot[2].action      = ACT_CLEAR;
		push.slot[2].phys_row    = to6(top_q);
		push.slot[2].column      = '0;
		push.slot[2].glyph       = '0;
		push.slot[2].top_row     = to6(top_next);
		push.slot[2].last_result = ~m[3];

		push.slot[3].action      = ACT_INVERT;
		push.slot[3].phys_row    = to6(phys_after);
		push.slot[3].column      = to7(col_next);
		push.slot[3].glyph       = '0;
		push.slot[3].top_row     = to6(top_next);
		push.slot[3].last_result = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q <= '0;
			cursor_row_q <= '0;
			top_q        <= '0;
		end else if (go) begin
			cursor_col_q <= col_next;
			cursor_row_q <= row_next;
			top_q        <= top_next;
		end
	end

endmodule

/* sv/tccs_outq.sv */
// result queue: takes up to four results a cycle, delivers one beat a cycle while out_stall is low
`timescale 1ns / 1ps
module tccs_outq import tccs_pkg::*; #(
	parameter int DEPTH = QDEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_stall,
	output res_t  head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	logic [1:0]       off [SLOTS];
	logic [2:0]       n;
	logic             pop;

	// compact the slot mask into consecutive queue positions
	always_comb begin
		off[0] = 2'd0;
		off[1] = {1'b0, push.mask[0]};
		off[2] = off[1] + {1'b0, push.mask[1]};
		off[3] = off[2] + {1'b0, push.mask[2]};
		n = {1'b0, off[3]} + {2'b0, push.mask[3]};
	end

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid & ~out_stall;
	assign head      = mem_q[rd_q];
	assign room      = cnt_q <= CNT_W'(DEPTH - SLOTS);

	always_ff @(posedge clk) begin
		for (int k = 0; k < SLOTS; k++) begin
			if (push.mask[k])
				mem_q[wr_q + PTR_W'(off[k])] <= push.slot[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + CNT_W'(n) - CNT_W'(pop);
		end
	end

endmodule

/* sv/text_console_cursor_scroll.sv */
// Text console cursor and scroll control.
//
// Input channel: one text byte per beat (char_code) with flags for the
// first and last byte of a write request. Output channel: one cell command
// per beat (draw glyph, clear physical row, invert cursor cell) with the
// current top row and a flag on the last command caused by each byte.
// A byte is taken into an input register; at the first edge at which the
// queue has room, all of its commands (up to four) are written into an
// 8-entry result queue while the cursor, row and top offset update; the first
// command appears on the output right after that edge.
// Throughput: one byte per cycle while bytes cause at most one command each
// and the receiver does not stall; the unstalled output moves one beat per
// cycle, so the queue depth and the one-beat output rate set the sustained
// figure. The input stalls while fewer than four queue entries are free.
// Reset clears the cursor to the top left, the top offset to zero and empties
// the queue. When the receiver stalls, the head command holds and the queue
// fills until the input side stalls as well.
`timescale 1ns / 1ps
module text_console_cursor_scroll import tccs_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       first_in_request,
	input  logic       last_in_request,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] action,
	output logic [5:0] phys_row,
	output logic [6:0] column,
	output logic [7:0] glyph,
	output logic [5:0] top_row,
	output logic       last_result
);

	push_t push;
	logic  room;
	res_t  head;

	tccs_core #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.char_code       (char_code),
		.first_in_request(first_in_request),
		.last_in_request (last_in_request),
		.room            (room),
		.push            (push)
	);

	tccs_outq #(
		.DEPTH(QDEPTH)
	) u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head     (head)
	);

	assign action      = head.action;
	assign phys_row    = head.phys_row;
	assign column      = head.column;
	assign glyph       = head.glyph;
	assign top_row     = head.top_row;
	assign last_result = head.last_result;

endmodule

/* sv/tccs_checker.sv */
// port-level checks for the text console cursor and scroll block
`timescale 1ns / 1ps
module tccs_checker import tccs_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] action,
	input logic [5:0] phys_row,
	input logic [6:0] column,
	input logic [7:0] glyph,
	input logic [5:0] top_row,
	input logic       last_result
);

	// a stalled beat keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable({action, phys_row, column, glyph, top_row, last_result}))
		else $error("output beat changed while stalled");

	// only draws carry a glyph, and a row clear always names column zero
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_DRAW |->
		glyph == 8'd0 && (action != ACT_CLEAR || column == 7'd0))
		else $error("non-draw beat carries glyph or column");

	// cells stay on the screen
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(column) < COLUMNS && 32'(phys_row) <= ROWS &&
		32'(top_row) <= ROWS)
		else $error("cell coordinates out of range");

	// a clear always closes the byte or is followed by the cursor redraw
	a_clear_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && action == ACT_CLEAR && !last_result |=>
		out_valid && action == ACT_INVERT)
		else $error("row clear not followed by cursor invert");

endmodule

bind text_console_cursor_scroll tccs_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tccs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.action     (action),
	.phys_row   (phys_row),
	.column     (column),
	.glyph      (glyph),
	.top_row    (top_row),
	.last_result(last_result)
);
